// ===== rtl/core/uhbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial port package
// Request and result types and shared constants of the half-bit timed
// asynchronous serial port.
// ----------------------------------------------------------------------------
package uhbt_pkg;

  localparam int DATA_BITS_DEFAULT = 8;
  localparam int TIMER_W = 16;
  localparam int HALF_INDEX_W = 5;
  localparam logic [TIMER_W-1:0] HALF_BIT_RESET = 16'd48;

  typedef struct packed {
    logic       send_req;
    logic [7:0] send_byte;
    logic       rx_pin;
  } in_t;

  typedef struct packed {
    logic       tx_pin;
    logic       tx_busy;
    logic       tx_done;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_error;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/uart_8n1_half_bit_timed.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Half-bit timed serial port
// Transmitter and receiver for asynchronous frames of one start bit, data
// bits least significant first and one stop bit, timed in half-bit periods.
// ----------------------------------------------------------------------------
// Each request is one clock cycle of the serial line: it carries the receive
// pin level and an optional send request. One result comes back for every
// request, showing the line and status after that cycle. A request is taken
// in every cycle while results are being taken, and its result is
// registered. The result side has an output register and a skid stage:
// while one result waits to be taken, one further request is still accepted
// into the skid stage, and the input then stalls until the waiting result
// has been taken. The timers advance only on accepted requests, so a stall
// on either side simply pauses the serial timing. half_bit_cycles is written
// through cfg_we and cfg_data, and a value of zero acts as one.
module uart_8n1_half_bit_timed
  import uhbt_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [TIMER_W-1:0]   cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output out_t                out_data
);

  localparam int WIDE_W = (DATA_BITS > 8) ? DATA_BITS : 8;
  localparam int IDX_W = $clog2(DATA_BITS);
  localparam logic [HALF_INDEX_W-1:0] FRAME_HALVES = HALF_INDEX_W'(2 * (DATA_BITS + 2));
  localparam logic [HALF_INDEX_W-2:0] LAST_DATA_BIT = (HALF_INDEX_W-1)'(DATA_BITS);

  logic [TIMER_W-1:0]      half_bit_cycles;
  logic [TIMER_W-1:0]      half_len;

  logic [TIMER_W-1:0]      tx_timer, tx_timer_next;
  logic [HALF_INDEX_W-1:0] tx_half_index, tx_half_index_next;
  logic [DATA_BITS-1:0]    tx_shift, tx_shift_next;
  logic                    tx_active, tx_active_next;
  logic [TIMER_W-1:0]      rx_timer, rx_timer_next;
  logic [HALF_INDEX_W-1:0] rx_half_index, rx_half_index_next;
  logic [DATA_BITS-1:0]    rx_shift, rx_shift_next;
  logic                    rx_active, rx_active_next;
  logic                    rx_bad, rx_bad_next;
  logic [7:0]              rx_data, rx_data_next;

  logic                    tx_tick, rx_tick;
  logic                    tx_done, rx_valid, rx_error;
  logic [HALF_INDEX_W-2:0] tx_bit, rx_bit;
  logic                    tx_level;
  logic [WIDE_W-1:0]       rx_wide;
  out_t                    result;

  logic                    accept;
  logic                    out_free;
  logic                    skid_valid;
  out_t                    skid_data;

  assign half_len = (half_bit_cycles == '0) ? TIMER_W'(1) : half_bit_cycles;
  assign tx_tick = ({1'b0, tx_timer} + 17'd1) >= {1'b0, half_len};
  assign rx_tick = ({1'b0, rx_timer} + 17'd1) >= {1'b0, half_len};

  always_comb begin
    tx_timer_next      = tx_timer;
    tx_half_index_next = tx_half_index;
    tx_shift_next      = tx_shift;
    tx_active_next     = tx_active;
    tx_done            = 1'b0;
    if (tx_active) begin
      tx_timer_next = tx_tick ? '0 : tx_timer + TIMER_W'(1);
      if (tx_tick) begin
        tx_half_index_next = tx_half_index + HALF_INDEX_W'(1);
        if (tx_half_index_next >= FRAME_HALVES) begin
          tx_active_next     = 1'b0;
          tx_half_index_next = '0;
          tx_done            = 1'b1;
        end
      end
    end else if (in_data.send_req) begin
      tx_active_next     = 1'b1;
      tx_timer_next      = '0;
      tx_half_index_next = '0;
      tx_shift_next      = DATA_BITS'(WIDE_W'(in_data.send_byte));
    end
  end

  always_comb begin
    tx_bit   = tx_half_index_next[HALF_INDEX_W-1:1];
    tx_level = 1'b1;
    if (tx_active_next) begin
      if (tx_bit == '0) begin
        tx_level = 1'b0;
      end else if (tx_bit <= LAST_DATA_BIT) begin
        tx_level = tx_shift_next[IDX_W'(tx_bit - (HALF_INDEX_W-1)'(1))];
      end
    end
  end

  always_comb begin
    rx_timer_next      = rx_timer;
    rx_half_index_next = rx_half_index;
    rx_shift_next      = rx_shift;
    rx_active_next     = rx_active;
    rx_bad_next        = rx_bad;
    rx_data_next       = rx_data;
    rx_valid           = 1'b0;
    rx_error           = 1'b0;
    rx_bit             = rx_half_index[HALF_INDEX_W-1:1];
    rx_wide            = WIDE_W'(rx_shift);
    if (rx_active) begin
      rx_timer_next = rx_tick ? '0 : rx_timer + TIMER_W'(1);
      if (rx_tick) begin
        if (!rx_half_index[0]) begin
          if (rx_bit == '0) begin
            if (in_data.rx_pin) begin
              rx_bad_next = 1'b1;
            end
          end else if (rx_bit <= LAST_DATA_BIT) begin
            rx_shift_next = {in_data.rx_pin, rx_shift[DATA_BITS-1:1]};
          end else if (!in_data.rx_pin) begin
            rx_bad_next = 1'b1;
          end
        end
        rx_half_index_next = rx_half_index + HALF_INDEX_W'(1);
        rx_wide            = WIDE_W'(rx_shift_next);
        if (rx_half_index_next == HALF_INDEX_W'(2) && rx_bad_next) begin
          rx_error           = 1'b1;
          rx_active_next     = 1'b0;
          rx_half_index_next = '0;
        end else if (rx_half_index_next >= FRAME_HALVES) begin
          if (rx_bad_next) begin
            rx_error = 1'b1;
          end else begin
            rx_valid     = 1'b1;
            rx_data_next = rx_wide[7:0];
          end
          rx_active_next     = 1'b0;
          rx_half_index_next = '0;
        end
      end
    end else if (!in_data.rx_pin) begin
      rx_active_next     = 1'b1;
      rx_timer_next      = '0;
      rx_half_index_next = '0;
      rx_bad_next        = 1'b0;
    end
  end

  always_comb begin
    result.tx_pin   = tx_level;
    result.tx_busy  = tx_active_next;
    result.tx_done  = tx_done;
    result.rx_valid = rx_valid;
    result.rx_byte  = rx_data_next;
    result.rx_error = rx_error;
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_cycles <= HALF_BIT_RESET;
    end else if (cfg_we) begin
      half_bit_cycles <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_timer      <= '0;
      tx_half_index <= '0;
      tx_shift      <= '0;
      tx_active     <= 1'b0;
      rx_timer      <= '0;
      rx_half_index <= '0;
      rx_shift      <= '0;
      rx_active     <= 1'b0;
      rx_bad        <= 1'b0;
      rx_data       <= '0;
    end else if (accept) begin
      tx_timer      <= tx_timer_next;
      tx_half_index <= tx_half_index_next;
      tx_shift      <= tx_shift_next;
      tx_active     <= tx_active_next;
      rx_timer      <= rx_timer_next;
      rx_half_index <= rx_half_index_next;
      rx_shift      <= rx_shift_next;
      rx_active     <= rx_active_next;
      rx_bad        <= rx_bad_next;
      rx_data       <= rx_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/uhbt_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial port checker package
// Holds the cycle-accurate predictor of the half-bit timed serial port and
// the queue of line states it expects back, one per accepted request.
// ----------------------------------------------------------------------------
package uhbt_tb_pkg;
  import uhbt_pkg::*;

  localparam int FRAME_HALVES = 2 * (DATA_BITS_DEFAULT + 2);
  localparam int REPORT_LIMIT = 10;

  class uart_predictor;
    bit [TIMER_W-1:0]      half_bit;
    bit [TIMER_W-1:0]      tx_timer;
    bit [TIMER_W-1:0]      rx_timer;
    bit [HALF_INDEX_W-1:0] tx_half;
    bit [HALF_INDEX_W-1:0] rx_half;
    bit [7:0]              tx_shift;
    bit [7:0]              rx_shift;
    bit [7:0]              rx_last;
    bit                    tx_active;
    bit                    rx_active;
    bit                    rx_bad;
    out_t                  line_states[$];
    int                    mismatches;
    int                    checked;
    int                    good_frames;
    int                    frame_errors;
    int                    frames_sent;

    function new();
      half_bit = HALF_BIT_RESET;
    endfunction

    function void set_half_bit(bit [TIMER_W-1:0] value);
      half_bit = value;
    endfunction

    function int pending();
      return line_states.size();
    endfunction

    // A zero period acts as one; a shortened period ends the half at once.
    function bit half_done(inout bit [TIMER_W-1:0] timer);
      int unsigned len;
      len = (half_bit == 0) ? 1 : half_bit;
      if (int'(timer) + 1 >= len) begin
        timer = '0;
        return 1'b1;
      end
      timer = timer + 1'b1;
      return 1'b0;
    endfunction

    function void note_request(in_t req);
      out_t want;
      int   bit_no;
      bit   done;
      bit   valid;
      bit   err;
      done  = 1'b0;
      valid = 1'b0;
      err   = 1'b0;
      if (tx_active) begin
        if (half_done(tx_timer)) begin
          tx_half++;
          if (tx_half >= FRAME_HALVES) begin
            tx_active = 1'b0;
            tx_half   = '0;
            done      = 1'b1;
          end
        end
      end else if (req.send_req) begin
        tx_active = 1'b1;
        tx_timer  = '0;
        tx_half   = '0;
        tx_shift  = req.send_byte;
      end

      if (rx_active) begin
        if (half_done(rx_timer)) begin
          if (!rx_half[0]) begin
            bit_no = rx_half >> 1;
            if (bit_no == 0) begin
              if (req.rx_pin) rx_bad = 1'b1;
            end else if (bit_no <= DATA_BITS_DEFAULT) begin
              rx_shift = {req.rx_pin, rx_shift[7:1]};
            end else if (!req.rx_pin) begin
              rx_bad = 1'b1;
            end
          end
          rx_half++;
          if (rx_half == 2 && rx_bad) begin
            err       = 1'b1;
            rx_active = 1'b0;
            rx_half   = '0;
          end else if (rx_half >= FRAME_HALVES) begin
            if (rx_bad) begin
              err = 1'b1;
            end else begin
              valid   = 1'b1;
              rx_last = rx_shift;
            end
            rx_active = 1'b0;
            rx_half   = '0;
          end
        end
      end else if (!req.rx_pin) begin
        rx_active = 1'b1;
        rx_timer  = '0;
        rx_half   = '0;
        rx_bad    = 1'b0;
      end

      bit_no = tx_half >> 1;
      if (!tx_active) want.tx_pin = 1'b1;
      else if (bit_no == 0) want.tx_pin = 1'b0;
      else if (bit_no <= DATA_BITS_DEFAULT) want.tx_pin = tx_shift[bit_no-1];
      else want.tx_pin = 1'b1;
      want.tx_busy  = tx_active;
      want.tx_done  = done;
      want.rx_valid = valid;
      want.rx_byte  = rx_last;
      want.rx_error = err;
      good_frames  += valid;
      frame_errors += err;
      frames_sent  += done;
      line_states.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t  want;
      string bad;
      checked++;
      if (line_states.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result %0d: got %h with nothing pending.", checked, got);
        return;
      end
      want = line_states.pop_front();
      bad  = "";
      if (got.tx_pin !== want.tx_pin) bad = {bad, " tx_pin"};
      if (got.tx_busy !== want.tx_busy) bad = {bad, " tx_busy"};
      if (got.tx_done !== want.tx_done) bad = {bad, " tx_done"};
      if (got.rx_valid !== want.rx_valid) bad = {bad, " rx_valid"};
      if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
      if (got.rx_error !== want.rx_error) bad = {bad, " rx_error"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result %0d differs in%s: expected %h, got %h.", checked, bad, want, got);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/uart_8n1_half_bit_timed_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial port testbench
// Drives line samples and send requests into the half-bit timed serial port
// through a range of bit periods, with well-formed, broken and skewed receive
// frames, and checks every returned line state against a cycle predictor.
// ----------------------------------------------------------------------------
module uart_8n1_half_bit_timed_tb;
  import uhbt_pkg::*;
  import uhbt_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 145;
  localparam int SLOW_PHASE_ITEMS = 40;

  typedef enum int {FRAME_GOOD, FRAME_BAD_START, FRAME_BAD_STOP, FRAME_SKEWED,
                    LINE_NOISE} frame_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [TIMER_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;

  uart_predictor      sb;
  int                 quiet;
  int                 items_sent;
  int                 send_idle_pct;
  int                 stall_pct;
  int                 req_pct;
  int                 settings_used;
  bit [TIMER_W-1:0]   baud_plan [10] = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd2,
                                         16'd0, 16'd4, 16'd1, 16'd3, 16'd2};

  uart_8n1_half_bit_timed u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Accepted requests and results are taken from the values before the edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer.", quiet);
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic put(in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic line_item(bit pin);
    in_t req;
    req.send_req  = ($urandom_range(0, 99) < req_pct);
    req.send_byte = 8'($urandom_range(0, 255));
    req.rx_pin    = pin;
    put(req);
  endtask

  task automatic drive_frame(bit [7:0] data, int h, bit bad_stop);
    int  b;
    bit  lvl;
    for (b = 0; b < DATA_BITS_DEFAULT + 2; b++) begin
      if (b == 0) lvl = 1'b0;
      else if (b == DATA_BITS_DEFAULT + 1) lvl = !bad_stop;
      else lvl = data[b-1];
      repeat (2 * h) line_item(lvl);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_bit(bit [TIMER_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    sb.set_half_bit(value);
    settings_used++;
  endtask

  task automatic random_phase(int n);
    int          h;
    int          stop_at;
    int          pick;
    frame_kind_t kind;
    h       = (sb.half_bit == 0) ? 1 : ((sb.half_bit > 8) ? 2 : sb.half_bit);
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 65) ? FRAME_GOOD : (pick < 75) ? FRAME_BAD_START :
             (pick < 85) ? FRAME_BAD_STOP : (pick < 93) ? FRAME_SKEWED : LINE_NOISE;
      case (kind)
        FRAME_GOOD: begin
          drive_frame(8'($urandom_range(0, 255)), h, 1'b0);
        end
        FRAME_BAD_START: begin
          repeat ($urandom_range(1, h)) line_item(1'b0);
          repeat (2 * h) line_item(1'b1);
        end
        FRAME_BAD_STOP: begin
          drive_frame(8'($urandom_range(0, 255)), h, 1'b1);
        end
        FRAME_SKEWED: begin
          drive_frame(8'($urandom_range(0, 255)), $urandom_range(1, 4), 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 8)) line_item(1'($urandom_range(0, 1)));
        end
      endcase
      repeat ($urandom_range(0, 3)) line_item(1'b1);
    end
  endtask

  initial begin
    in_t      req;
    int       i;
    int       p;
    bit [7:0] pattern;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero period, a send request on every cycle and one clean frame, then a
    // start bit that is high again at its middle.
    write_half_bit(16'd0);
    pattern = 8'h5A;
    for (i = 0; i < 21; i++) begin
      req.send_req  = 1'b1;
      req.send_byte = i[0] ? 8'hFF : 8'h00;
      req.rx_pin    = (i < 2) ? 1'b0 : (i < 18) ? pattern[(i - 2) / 2] : 1'b1;
      put(req);
    end
    req.send_req = 1'b0;
    for (i = 0; i < 3; i++) begin
      req.rx_pin = (i != 0);
      put(req);
    end

    req_pct = 15;
    for (p = 0; p < 10; p++) begin
      drain();
      write_half_bit(baud_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      random_phase((baud_plan[p] > 16'd8) ? SLOW_PHASE_ITEMS : PHASE_ITEMS);
    end
    drain();

    $display("Covered %0d requests over %0d bit period settings and %0d results.",
             items_sent, settings_used, sb.checked);
    $display("Seen %0d good frames, %0d framing errors and %0d frames sent; %0d mismatches.",
             sb.good_frames, sb.frame_errors, sb.frames_sent, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
